// ----- rtl/core/scc_pkg.sv -----
`default_nettype none

package scc_pkg;

  localparam int unsigned REF_DEPTH = 1024;
  localparam int unsigned TIME_BITS = 32;

  localparam int unsigned SAMPLE_BITS = 32;
  localparam int unsigned WINDOW_BITS = 32;
  localparam int unsigned TOTAL_BITS  = 32;

  localparam int unsigned ADDR_BITS = $clog2(REF_DEPTH);
  localparam int unsigned LEN_BITS  = $clog2(REF_DEPTH + 1);
  // wide enough for x + window without wrap
  localparam int unsigned CALC_BITS =
    ((TIME_BITS > WINDOW_BITS) ? TIME_BITS : WINDOW_BITS) + 1;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_PROBE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BOUNDS,
    ST_LO_RD,
    ST_LO_CMP,
    ST_HI_RD,
    ST_HI_CMP,
    ST_ADD,
    ST_EMIT
  } scc_state_e;

  typedef struct packed {
    logic load;
    logic capture;
    logic bounds;
    logic rd_en;
    logic rd_sel_k;
    logic lptr_inc;
    logic start_count;
    logic k_inc;
    logic add;
    logic emit;
  } scc_cmd_t;

  typedef struct packed {
    logic lptr_lt_len;
    logic k_lt_len;
    logic below_lo;
    logic within_hi;
    logic last_probe;
    logic out_free;
  } scc_status_t;

endpackage

`default_nettype wire

// ----- rtl/core/spike_coincidence_counter.sv -----
`default_nettype none
// Channel   Handshake          Payload
// in        valid_i / stall_o  opcode_i, sample_time_i, last_item_i
// out       valid_o / stall_i  pair_count_o, saturated_o
// cfg       valid_i / ready_o  window_half_width_i
//
// A load is written while idle and does not stall the input. A probe stalls
// the input until done: it computes the bounds, walks the lower pointer, walks
// the count (one read and one compare per stored time, in either walk), adds,
// and for the last probe of a train emits, held while a stalled result still
// sits in the output register. Reset clears the length, pointer, total and
// window; the reference store holds no reset value.

module spike_coincidence_counter
  import scc_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic                   in_opcode_i,
  input  wire logic [SAMPLE_BITS-1:0] in_sample_time_i,
  input  wire logic                   in_last_item_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic      [TOTAL_BITS-1:0]  out_pair_count_o,
  output logic                        out_saturated_o,
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [WINDOW_BITS-1:0] cfg_window_half_width_i
);

  scc_cmd_t    cmd;
  scc_status_t status;

  // the window register takes a transfer in any cycle
  assign cfg_ready_o = 1'b1;

  // sequence each probe: bounds, lower-pointer walk, count walk, add, emit
  scc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_opcode_i(in_opcode_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // hold the reference store, pointers, total and output register
  scc_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .sample_time_i   (in_sample_time_i),
    .last_item_i     (in_last_item_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_window_i    (cfg_window_half_width_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_pair_count_o(out_pair_count_o),
    .out_saturated_o (out_saturated_o)
  );

endmodule

`default_nettype wire

// ----- rtl/core/scc_ram.sv -----
`default_nettype none

module scc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/scc_ctrl.sv -----
`default_nettype none

module scc_ctrl
  import scc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_opcode_i,
  output logic             in_stall_o,
  input  wire scc_status_t status_i,
  output scc_cmd_t         cmd_o
);

  scc_state_e state_q, state_d;
  logic       accept;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (in_opcode_i == OP_PROBE)) state_d = ST_BOUNDS;
      end
      ST_BOUNDS: state_d = ST_LO_RD;
      ST_LO_RD: begin
        state_d = status_i.lptr_lt_len ? ST_LO_CMP : ST_HI_RD;
      end
      ST_LO_CMP: begin
        state_d = status_i.below_lo ? ST_LO_RD : ST_HI_RD;
      end
      ST_HI_RD: begin
        state_d = status_i.k_lt_len ? ST_HI_CMP : ST_ADD;
      end
      ST_HI_CMP: begin
        state_d = status_i.within_hi ? ST_HI_RD : ST_ADD;
      end
      ST_ADD: begin
        state_d = status_i.last_probe ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.load    = accept && (in_opcode_i == OP_LOAD);
        cmd_o.capture = accept && (in_opcode_i == OP_PROBE);
      end
      ST_BOUNDS: cmd_o.bounds = 1'b1;
      ST_LO_RD: begin
        cmd_o.rd_en       = status_i.lptr_lt_len;
        cmd_o.start_count = !status_i.lptr_lt_len;
      end
      ST_LO_CMP: begin
        cmd_o.lptr_inc    = status_i.below_lo;
        cmd_o.start_count = !status_i.below_lo;
      end
      ST_HI_RD: begin
        cmd_o.rd_en    = status_i.k_lt_len;
        cmd_o.rd_sel_k = 1'b1;
      end
      ST_HI_CMP: cmd_o.k_inc = status_i.within_hi;
      ST_ADD:    cmd_o.add = 1'b1;
      ST_EMIT:   cmd_o.emit = status_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/core/scc_datapath.sv -----
`default_nettype none

module scc_datapath
  import scc_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire scc_cmd_t               cmd_i,
  output scc_status_t                 status_o,
  input  wire logic [SAMPLE_BITS-1:0] sample_time_i,
  input  wire logic                   last_item_i,
  input  wire logic                   cfg_valid_i,
  input  wire logic [WINDOW_BITS-1:0] cfg_window_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic      [TOTAL_BITS-1:0]  out_pair_count_o,
  output logic                        out_saturated_o
);

  localparam logic [CALC_BITS-1:0] TIME_MAX_C =
    (CALC_BITS'(1) << TIME_BITS) - CALC_BITS'(1);
  localparam logic [LEN_BITS-1:0] DEPTH_C = LEN_BITS'(REF_DEPTH);

  logic [WINDOW_BITS-1:0] win_q;
  logic [LEN_BITS-1:0]    len_q, lptr_q, k_q, added_q;
  logic [TOTAL_BITS-1:0]  total_q;
  logic                   ovf_q, closed_q, last_q, out_valid_q;
  logic [TIME_BITS-1:0]   x_q, lo_q, hi_q;
  logic [TOTAL_BITS-1:0]  out_count_q;
  logic                   out_sat_q;

  logic [TIME_BITS-1:0]   x_in, rdata;
  logic                   wr_en;
  logic [ADDR_BITS-1:0]   wr_addr, rd_addr;
  logic [CALC_BITS-1:0]   xe, we, hi_sum;
  logic [TIME_BITS-1:0]   lo_d, hi_d;
  logic [TOTAL_BITS:0]    sum;

  assign x_in    = TIME_BITS'(sample_time_i);
  // a load after a closed train starts over at entry zero; a full store drops it
  assign wr_en   = cmd_i.load && (closed_q || (len_q < DEPTH_C));
  assign wr_addr = closed_q ? '0 : len_q[ADDR_BITS-1:0];
  assign rd_addr = cmd_i.rd_sel_k ? k_q[ADDR_BITS-1:0] : lptr_q[ADDR_BITS-1:0];

  scc_ram #(
    .WIDTH(TIME_BITS),
    .DEPTH(REF_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(wr_addr),
    .wdata_i(x_in),
    .re_i   (cmd_i.rd_en),
    .raddr_i(rd_addr),
    .rdata_o(rdata)
  );

  // saturating window bounds
  assign xe     = CALC_BITS'(x_q);
  assign we     = CALC_BITS'(win_q);
  assign hi_sum = xe + we;
  assign lo_d   = (xe > we) ? TIME_BITS'(xe - we) : '0;
  assign hi_d   = (hi_sum > TIME_MAX_C) ? TIME_BITS'(TIME_MAX_C) : TIME_BITS'(hi_sum);

  assign sum = {1'b0, total_q} + (TOTAL_BITS + 1)'(added_q);

  always_comb begin
    status_o.lptr_lt_len = (lptr_q < len_q);
    status_o.k_lt_len    = (k_q < len_q);
    status_o.below_lo    = (rdata < lo_q);
    status_o.within_hi   = (rdata <= hi_q);
    status_o.last_probe  = last_q;
    status_o.out_free    = !out_valid_q || !out_stall_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q       <= '0;
      len_q       <= '0;
      lptr_q      <= '0;
      total_q     <= '0;
      ovf_q       <= 1'b0;
      closed_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) win_q <= cfg_window_i;

      if (cmd_i.load) begin
        if (closed_q) begin
          len_q    <= LEN_BITS'(1);
          lptr_q   <= '0;
          total_q  <= '0;
          ovf_q    <= 1'b0;
        end else if (len_q < DEPTH_C) begin
          len_q <= len_q + LEN_BITS'(1);
        end
        closed_q <= last_item_i;
      end

      if (cmd_i.capture) closed_q <= 1'b1;
      if (cmd_i.lptr_inc) lptr_q <= lptr_q + LEN_BITS'(1);

      if (cmd_i.add) begin
        if (sum[TOTAL_BITS]) begin
          total_q <= '1;
          ovf_q   <= 1'b1;
        end else begin
          total_q <= sum[TOTAL_BITS-1:0];
        end
      end

      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
        total_q     <= '0;
        ovf_q       <= 1'b0;
        lptr_q      <= '0;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      x_q    <= x_in;
      last_q <= last_item_i;
    end
    if (cmd_i.bounds) begin
      lo_q <= lo_d;
      hi_q <= hi_d;
    end
    if (cmd_i.start_count) begin
      k_q     <= lptr_q;
      added_q <= '0;
    end
    if (cmd_i.k_inc) begin
      k_q     <= k_q + LEN_BITS'(1);
      added_q <= added_q + LEN_BITS'(1);
    end
    if (cmd_i.emit) begin
      out_count_q <= total_q;
      out_sat_q   <= ovf_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_pair_count_o = out_count_q;
  assign out_saturated_o  = out_sat_q;

endmodule

`default_nettype wire
